/* rtl/core/dstfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dstfp_pkg
// Shared types, constants and tables for the decimal string to fixed point
// converter.
// ----------------------------------------------------------------------------
package dstfp_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int MAX_FRAC_DIGITS = 9;

    localparam int CHAR_W   = 8;
    localparam int INT_W    = 40;
    localparam int FRAC_W   = 30;
    localparam int FCNT_W   = 4;
    localparam int VALUE_W  = 64;
    localparam int DIV_CNT_W = $clog2(FRAC_BITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    // integer part saturates at min(2^INT_W - 1, 2^(63 - FRAC_BITS) - 1)
    localparam logic [63:0] HEADROOM_LIMIT = (64'd1 << (63 - FRAC_BITS)) - 64'd1;
    localparam logic [63:0] INT_MASK       = (64'd1 << INT_W) - 64'd1;
    localparam logic [63:0] INT_LIMIT_64   =
        (HEADROOM_LIMIT < INT_MASK) ? HEADROOM_LIMIT : INT_MASK;
    localparam logic [INT_W-1:0] INT_LIMIT = INT_LIMIT_64[INT_W-1:0];

    typedef enum logic [1:0] {
        ST_RUN,
        ST_LAUNCH,
        ST_DIV,
        ST_DONE
    } dstfp_state_t;

    // accumulated view of the string so far
    typedef struct packed {
        logic [INT_W-1:0]  int_val;
        logic [FRAC_W-1:0] frac_val;
        logic [FCNT_W-1:0] frac_cnt;
        logic              negative;
        logic              bad;
        logic              sat;
    } dstfp_acc_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dstfp_div_stat_t;

    function automatic logic [FRAC_W-1:0] pow_ten(input logic [FCNT_W-1:0] k);
        logic [FRAC_W-1:0] p;
        begin
            case (k)
                4'd0:    p = 30'd1;
                4'd1:    p = 30'd10;
                4'd2:    p = 30'd100;
                4'd3:    p = 30'd1000;
                4'd4:    p = 30'd10000;
                4'd5:    p = 30'd100000;
                4'd6:    p = 30'd1000000;
                4'd7:    p = 30'd10000000;
                4'd8:    p = 30'd100000000;
                default: p = 30'd1000000000;
            endcase
            return p;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/core/decimal_string_to_fixed_point.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequence: after the last character is accepted the FSM runs ST_LAUNCH,
//   ST_DIV (bit-serial fraction divider) and ST_DONE, which loads the result.
// Throughput: one character per cycle while in ST_RUN; input is stalled
//   from the last character until the result is loaded in ST_DONE.
// Reset: synchronous active-low aresetn clears the parser, divider and
//   output valid; s_tready is high as soon as reset is released.
// ----------------------------------------------------------------------------
// decimal_string_to_fixed_point
// ASCII decimal string to signed fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module decimal_string_to_fixed_point (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic        s_tlast,   // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [63:0] value
    output logic [1:0]       m_tuser    // [0] is_valid, [1] overflowed
);

    dstfp_pkg::dstfp_state_t    state_reg, state_next;
    dstfp_pkg::dstfp_acc_t      acc;
    dstfp_pkg::dstfp_div_stat_t div_stat;

    logic [dstfp_pkg::FRAC_BITS-1:0] quot;
    logic                            take;
    logic                            start;
    logic                            load;

    logic [dstfp_pkg::VALUE_W-1:0]   mag;
    logic [dstfp_pkg::VALUE_W-1:0]   value_calc;

    logic                            m_valid_reg, m_valid_next;
    logic [dstfp_pkg::VALUE_W-1:0]   m_data_reg;
    logic [1:0]                      m_user_reg;

    assign take = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        start      = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            dstfp_pkg::ST_RUN: begin
                s_tready = 1'b1;
                if (take && s_tlast) begin
                    state_next = dstfp_pkg::ST_LAUNCH;
                end
            end
            dstfp_pkg::ST_LAUNCH: begin
                start      = 1'b1;
                state_next = dstfp_pkg::ST_DIV;
            end
            dstfp_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    state_next = dstfp_pkg::ST_DONE;
                end
            end
            dstfp_pkg::ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    load       = 1'b1;
                    state_next = dstfp_pkg::ST_RUN;
                end
            end
            default: state_next = dstfp_pkg::ST_RUN;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dstfp_pkg::ST_RUN;
        end else begin
            state_reg <= state_next;
        end
    end

    dstfp_char_acc u_char_acc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take_i  (take),
        .char_i  (s_tdata),
        .clear_i (load),
        .acc_o   (acc)
    );

    dstfp_frac_div u_frac_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (start),
        .dividend_i (acc.frac_val),
        .divisor_i  (dstfp_pkg::pow_ten(acc.frac_cnt)),
        .quot_o     (quot),
        .stat_o     (div_stat)
    );

    // quotient is below 2^FRAC_BITS, so the sum is a plain concatenation
    assign mag        = (dstfp_pkg::VALUE_W'(acc.int_val) << dstfp_pkg::FRAC_BITS)
                      | dstfp_pkg::VALUE_W'(quot);
    assign value_calc = acc.negative ? (dstfp_pkg::VALUE_W'(0) - mag) : mag;

    assign m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            if (acc.bad) begin
                m_data_reg <= '1;
                m_user_reg <= 2'b00;
            end else begin
                m_data_reg <= value_calc;
                m_user_reg <= {acc.sat, 1'b1};
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !div_stat.busy)
        else $error("divider restarted while busy");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == dstfp_pkg::ST_DIV))
        else $error("divider done outside of divide state");

    a_clear_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load |=> (acc.frac_cnt == '0) && !acc.bad && !acc.sat && (acc.int_val == '0))
        else $error("accumulators not cleared after result");

    a_error_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> ((m_tdata == '1) && !m_tuser[1]))
        else $error("malformed string result not minus one");

    a_frac_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        acc.frac_cnt <= dstfp_pkg::FCNT_W'(dstfp_pkg::MAX_FRAC_DIGITS))
        else $error("fraction digit count out of range");

endmodule
`default_nettype wire

/* rtl/core/dstfp_char_acc.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dstfp_char_acc
// Character parser: tracks sign, point and errors, and accumulates the
// integer digits and the fraction digits of one string.
// ----------------------------------------------------------------------------
module dstfp_char_acc (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          take_i,
    input  wire logic [dstfp_pkg::CHAR_W-1:0]  char_i,
    input  wire logic                          clear_i,
    output dstfp_pkg::dstfp_acc_t              acc_o
);

    logic [dstfp_pkg::INT_W-1:0]  int_reg,  int_next;
    logic [dstfp_pkg::FRAC_W-1:0] frac_reg, frac_next;
    logic [dstfp_pkg::FCNT_W-1:0] cnt_reg,  cnt_next;
    logic neg_reg,   neg_next;
    logic point_reg, point_next;
    logic first_reg, first_next;
    logic bad_reg,   bad_next;
    logic sat_reg,   sat_next;

    logic                          is_digit;
    logic [3:0]                    digit;
    logic [dstfp_pkg::INT_W+3:0]   int_mul;
    logic [dstfp_pkg::FRAC_W+3:0]  frac_mul;

    assign is_digit = (char_i >= dstfp_pkg::CHAR_ZERO) && (char_i <= dstfp_pkg::CHAR_NINE);
    assign digit    = 4'(char_i - dstfp_pkg::CHAR_ZERO);

    // x*10 + d as shift-add
    assign int_mul  = {1'b0, int_reg, 3'b000} + {3'b000, int_reg, 1'b0}
                    + (dstfp_pkg::INT_W+4)'(digit);
    assign frac_mul = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0}
                    + (dstfp_pkg::FRAC_W+4)'(digit);

    always_comb begin
        int_next   = int_reg;
        frac_next  = frac_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        point_next = point_reg;
        first_next = first_reg;
        bad_next   = bad_reg;
        sat_next   = sat_reg;
        if (clear_i) begin
            int_next   = '0;
            frac_next  = '0;
            cnt_next   = '0;
            neg_next   = 1'b0;
            point_next = 1'b0;
            first_next = 1'b1;
            bad_next   = 1'b0;
            sat_next   = 1'b0;
        end else if (take_i) begin
            first_next = 1'b0;
            if (!bad_reg) begin
                if (char_i == dstfp_pkg::CHAR_MINUS) begin
                    if (first_reg) begin
                        neg_next = 1'b1;
                    end else begin
                        bad_next = 1'b1;
                    end
                end else if (char_i == dstfp_pkg::CHAR_POINT) begin
                    if (point_reg) begin
                        bad_next = 1'b1;
                    end else begin
                        point_next = 1'b1;
                    end
                end else if (is_digit) begin
                    if (!point_reg) begin
                        if (int_mul > (dstfp_pkg::INT_W+4)'(dstfp_pkg::INT_LIMIT)) begin
                            int_next = dstfp_pkg::INT_LIMIT;
                            sat_next = 1'b1;
                        end else begin
                            int_next = int_mul[dstfp_pkg::INT_W-1:0];
                        end
                    end else if (cnt_reg < dstfp_pkg::FCNT_W'(dstfp_pkg::MAX_FRAC_DIGITS)) begin
                        frac_next = frac_mul[dstfp_pkg::FRAC_W-1:0];
                        cnt_next  = cnt_reg + dstfp_pkg::FCNT_W'(1);
                    end
                end else begin
                    bad_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            int_reg   <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            point_reg <= 1'b0;
            first_reg <= 1'b1;
            bad_reg   <= 1'b0;
            sat_reg   <= 1'b0;
        end else begin
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            point_reg <= point_next;
            first_reg <= first_next;
            bad_reg   <= bad_next;
            sat_reg   <= sat_next;
        end
    end

    assign acc_o.int_val  = int_reg;
    assign acc_o.frac_val = frac_reg;
    assign acc_o.frac_cnt = cnt_reg;
    assign acc_o.negative = neg_reg;
    assign acc_o.bad      = bad_reg;
    assign acc_o.sat      = sat_reg;

endmodule
`default_nettype wire

/* rtl/core/dstfp_frac_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dstfp_frac_div
// Radix-2 restoring divider producing floor(F * 2^FRAC_BITS / D) for F < D,
// one quotient bit per cycle through a shared compare/subtract.
// ----------------------------------------------------------------------------
module dstfp_frac_div (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            start_i,
    input  wire logic [dstfp_pkg::FRAC_W-1:0]    dividend_i,
    input  wire logic [dstfp_pkg::FRAC_W-1:0]    divisor_i,
    output logic [dstfp_pkg::FRAC_BITS-1:0]      quot_o,
    output dstfp_pkg::dstfp_div_stat_t           stat_o
);

    logic [dstfp_pkg::FRAC_W-1:0]    rem_reg,  rem_next;
    logic [dstfp_pkg::FRAC_W-1:0]    dvs_reg,  dvs_next;
    logic [dstfp_pkg::FRAC_BITS-1:0] quot_reg, quot_next;
    logic [dstfp_pkg::DIV_CNT_W-1:0] cnt_reg,  cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;

    logic [dstfp_pkg::FRAC_W:0]      rem2;
    logic [dstfp_pkg::FRAC_W:0]      diff;
    logic                            ge;

    assign rem2 = {rem_reg, 1'b0};
    assign diff = rem2 - {1'b0, dvs_reg};
    assign ge   = rem2 >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start_i) begin
            rem_next  = dividend_i;
            dvs_next  = divisor_i;
            quot_next = '0;
            cnt_next  = dstfp_pkg::DIV_CNT_W'(dstfp_pkg::FRAC_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits FRAC_W bits
            rem_next  = ge ? diff[dstfp_pkg::FRAC_W-1:0] : rem2[dstfp_pkg::FRAC_W-1:0];
            quot_next = {quot_reg[dstfp_pkg::FRAC_BITS-2:0], ge};
            cnt_next  = cnt_reg - dstfp_pkg::DIV_CNT_W'(1);
            if (cnt_reg == dstfp_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign quot_o      = quot_reg;
    assign stat_o.busy = busy_reg;
    assign stat_o.done = done_reg;

endmodule
`default_nettype wire

/* sim/decimal_string_to_fixed_point_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_string_to_fixed_point_tb
// Streams ASCII number strings into the converter one character per request
// and checks every converted value and its flags against a behavioral model
// of the parser that runs alongside. Directed strings cover the corner cases.
// Random strings follow: mostly well-formed, some broken, some noise. Both
// sides of the stream are throttled in two phases, then run unthrottled.
// ----------------------------------------------------------------------------
module decimal_string_to_fixed_point_tb;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = dstfp_pkg::FRAC_BITS + 8;
    localparam int TOTAL_CHARS  = 700;

    // integer part clamps at the smaller of the accumulator range and the
    // headroom left above the fraction bits
    localparam logic [63:0] ACC_MAX  = (64'd1 << 40) - 64'd1;
    localparam logic [63:0] ROOM_MAX = (64'd1 << (63 - dstfp_pkg::FRAC_BITS)) - 64'd1;
    localparam logic [63:0] SAT_MAX  = (ROOM_MAX < ACC_MAX) ? ROOM_MAX : ACC_MAX;

    typedef struct {
        logic [63:0] value;
        logic        is_valid;
        logic        overflowed;
    } conv_result_t;

    class number_parser_model;
        logic [39:0]  int_acc;
        logic [29:0]  frac_acc;
        logic [3:0]   frac_cnt;
        logic         negative;
        logic         seen_point;
        logic         at_first;
        logic         bad;
        logic         sat;
        conv_result_t expected_values[$];
        int           errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            int_acc    = '0;
            frac_acc   = '0;
            frac_cnt   = '0;
            negative   = 1'b0;
            seen_point = 1'b0;
            at_first   = 1'b1;
            bad        = 1'b0;
            sat        = 1'b0;
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        // one accepted character; a last character closes the string
        function void note_char(logic [7:0] c, logic last);
            logic         was_first;
            logic [63:0]  grown;
            logic [63:0]  d;
            logic [63:0]  scale;
            logic [63:0]  value;
            conv_result_t r;
            was_first = at_first;
            at_first  = 1'b0;
            d = 64'(c - dstfp_pkg::CHAR_ZERO);
            if (!bad) begin
                if (c == dstfp_pkg::CHAR_MINUS) begin
                    if (was_first) negative = 1'b1;
                    else bad = 1'b1;
                end else if (c == dstfp_pkg::CHAR_POINT) begin
                    if (seen_point) bad = 1'b1;
                    else seen_point = 1'b1;
                end else if (c >= dstfp_pkg::CHAR_ZERO && c <= dstfp_pkg::CHAR_NINE) begin
                    if (!seen_point) begin
                        grown = 64'(int_acc) * 64'd10 + d;
                        if (grown > SAT_MAX) begin
                            grown = SAT_MAX;
                            sat   = 1'b1;
                        end
                        int_acc = grown[39:0];
                    end else if (frac_cnt < dstfp_pkg::MAX_FRAC_DIGITS && frac_cnt < 9) begin
                        grown    = 64'(frac_acc) * 64'd10 + d;
                        frac_acc = grown[29:0];
                        frac_cnt = frac_cnt + 4'd1;
                    end
                end else begin
                    bad = 1'b1;
                end
            end
            if (!last) return;

            if (bad) begin
                r.value      = '1;
                r.is_valid   = 1'b0;
                r.overflowed = 1'b0;
            end else begin
                scale = 64'd1;
                for (int i = 0; i < frac_cnt && i < 9; i++) scale = scale * 64'd10;
                value = (64'(int_acc) << dstfp_pkg::FRAC_BITS)
                      + ((64'(frac_acc) << dstfp_pkg::FRAC_BITS) / scale);
                if (negative) value = 64'd0 - value;
                r.value      = value;
                r.is_valid   = 1'b1;
                r.overflowed = sat;
            end
            expected_values.push_back(r);
            clear();
        endfunction

        function void check_value(logic [63:0] got_value, logic [1:0] got_flags);
            conv_result_t exp_r;
            if (expected_values.size() == 0) begin
                $error("result with no string pending: value %h flags %b",
                       got_value, got_flags);
                errors++;
                return;
            end
            exp_r = expected_values.pop_front();
            if (got_value !== exp_r.value) begin
                $error("value: expected %h, got %h", exp_r.value, got_value);
                errors++;
            end
            if (got_flags[0] !== exp_r.is_valid) begin
                $error("is_valid: expected %b, got %b", exp_r.is_valid, got_flags[0]);
                errors++;
            end
            if (got_flags[1] !== exp_r.overflowed) begin
                $error("overflowed: expected %b, got %b", exp_r.overflowed, got_flags[1]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] char_code
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;    // [63:0] value
    logic [1:0]  m_tuser;    // [0] is_valid, [1] overflowed

    number_parser_model parser;
    logic [7:0]         num_text[$];
    int                 chars_sent;
    int                 src_idle_pct;
    int                 sink_idle_pct;
    int                 stall_cycles;

    decimal_string_to_fixed_point i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready = ($urandom_range(0, 99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            parser.check_value(m_tdata, m_tuser);
        end
    end

    // watchdog: give up when no request moves on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("decimal_string_to_fixed_point test failed");
                $finish;
            end
        end
    end

    function automatic logic [7:0] rand_digit();
        return dstfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // any byte that is not a digit, sign or point
    function automatic logic [7:0] rand_junk();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while ((c >= dstfp_pkg::CHAR_ZERO && c <= dstfp_pkg::CHAR_NINE)
               || c == dstfp_pkg::CHAR_MINUS || c == dstfp_pkg::CHAR_POINT)
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic void load_text(string s);
        num_text.delete();
        for (int i = 0; i < s.len(); i++) num_text.push_back(s[i]);
    endfunction

    function automatic void build_number();
        int n_int;
        int n_frac;
        num_text.delete();
        if ($urandom_range(0, 2) == 0) num_text.push_back(dstfp_pkg::CHAR_MINUS);
        // now and then a long integer part to push into saturation
        n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 4);
        for (int i = 0; i < n_int; i++) begin
            if (i == 0 && n_int > 10)
                num_text.push_back(dstfp_pkg::CHAR_ZERO + 8'($urandom_range(1, 9)));
            else num_text.push_back(rand_digit());
        end
        if ($urandom_range(0, 3) != 0) begin
            num_text.push_back(dstfp_pkg::CHAR_POINT);
            n_frac = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
            for (int i = 0; i < n_frac; i++) num_text.push_back(rand_digit());
        end
        if (num_text.size() == 0) num_text.push_back(rand_digit());
    endfunction

    function automatic void build_random_string();
        int         pick;
        int         pos;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            build_number();
        end else if (pick < 85) begin
            // usually broken: a stray sign, point or junk byte after the first char
            build_number();
            case ($urandom_range(0, 2))
                0:       c = dstfp_pkg::CHAR_MINUS;
                1:       c = dstfp_pkg::CHAR_POINT;
                default: c = rand_junk();
            endcase
            pos = $urandom_range(1, num_text.size());
            num_text.insert(pos, c);
        end else begin
            num_text.delete();
            for (int i = $urandom_range(1, 4); i > 0; i--)
                num_text.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    task automatic send_number();
        foreach (num_text[i]) begin
            @(negedge aclk);
            while ($urandom_range(0, 99) < src_idle_pct) begin
                s_tvalid = 1'b0;
                s_tdata  = 8'($urandom_range(0, 255));
                s_tlast  = 1'($urandom_range(0, 1));
                @(negedge aclk);
            end
            s_tvalid = 1'b1;
            s_tdata  = num_text[i];
            s_tlast  = (i == num_text.size() - 1);
            @(posedge aclk);
            while (!s_tready) @(posedge aclk);
            parser.note_char(num_text[i], i == num_text.size() - 1);
            chars_sent++;
        end
    endtask

    task automatic send_text(string s);
        load_text(s);
        send_number();
    endtask

    task automatic run_random(int upto);
        while (chars_sent < upto) begin
            build_random_string();
            send_number();
        end
    endtask

    initial begin
        parser        = new();
        chars_sent    = 0;
        stall_cycles  = 0;
        src_idle_pct  = 14;
        sink_idle_pct = 62;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // corner cases: plain values, no digits, sign only, bad sign, second point, junk
        send_text("0");
        send_text(".");
        send_text("-");
        send_text("-.");
        send_text("9.5");
        send_text("-12");
        send_text("1-2");
        send_text("..");
        send_text("x5");
        num_text = '{8'h00};
        send_number();
        num_text = '{8'hFF};
        send_number();

        run_random(TOTAL_CHARS / 3);
        src_idle_pct  = 62;
        sink_idle_pct = 14;
        run_random(2 * TOTAL_CHARS / 3);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        run_random(TOTAL_CHARS);

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (parser.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (parser.errors == 0) begin
            $display("decimal_string_to_fixed_point test passed");
        end else begin
            $display("decimal_string_to_fixed_point test failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/dstfp_pkg.sv
rtl/core/dstfp_char_acc.sv
rtl/core/dstfp_frac_div.sv
rtl/core/decimal_string_to_fixed_point.sv
sim/decimal_string_to_fixed_point_tb.sv
